/* hdl/fbfp_pkg.sv */
// Types, constants and helpers for the file block frame parser.
package fbfp_pkg;

    localparam int BLOCK_MAX  = 1024;
    localparam int NAME_MAX   = 64;
    localparam int PREFIX_LEN = 12;
    localparam int MAX_DIGITS = 9;

    localparam int VAL_W    = 30;
    localparam int CNT_W    = $clog2(BLOCK_MAX + 1);
    localparam int NAME_W   = $clog2(NAME_MAX);
    localparam int PREFIX_W = $clog2(PREFIX_LEN + 1);
    localparam int DIGIT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_BELL  = 8'h07;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_VERDICT = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'd0,
        PH_NAME    = 4'd1,
        PH_COUNT   = 4'd2,
        PH_BLOCK   = 4'd3,
        PH_SIZE    = 4'd4,
        PH_DATA    = 4'd5,
        PH_CKHI    = 4'd6,
        PH_CKLO    = 4'd7,
        PH_DISCARD = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic [VAL_W-1:0]   block_number;
        logic [VAL_W-1:0]   file_size;
        logic [CNT_W-1:0]   byte_count;
        logic               checksum_ok;
        logic               file_missing;
        logic [7:0]         checksum_received;
    } out_item_t;

    // Expected character at each position of "FDFILEBLOCK,"
    function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h46;
            4'd1:    c = 8'h44;
            4'd2:    c = 8'h46;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h42;
            4'd7:    c = 8'h4C;
            4'd8:    c = 8'h4F;
            4'd9:    c = 8'h43;
            4'd10:   c = 8'h4B;
            4'd11:   c = CHAR_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, value} of one hex digit, either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

/* hdl/file_block_frame_parser_top.sv */
// Top level: byte-at-a-time parser for one file block line.
//
//  channel   direction  handshake             payload
//  rx        in         rx_valid / rx_ready   rx_item  (in_item_t)
//  res       out        res_valid / res_ready res_item (out_item_t)
//
// One byte per cycle; the result (if any) appears in the result register
// the cycle after the byte is taken. rx_ready is low only while a result
// sits in the output register and res_ready is low. Reset (rst_n, async)
// puts the parser at the start of a line with the output register empty.
module file_block_frame_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  fbfp_pkg::in_item_t  rx_item,
    output logic                res_valid,
    input  logic                res_ready,
    output fbfp_pkg::out_item_t res_item
);
    import fbfp_pkg::*;

    phase_t                phase_reg,    phase_next;
    logic [PREFIX_W-1:0]   prefix_reg,   prefix_next;
    logic [NAME_W-1:0]     name_len_reg, name_len_next;
    logic [DIGIT_W-1:0]    digits_reg,   digits_next;
    logic [VAL_W-1:0]      count_reg,    count_next;
    logic [VAL_W-1:0]      block_reg,    block_next;
    logic [VAL_W-1:0]      size_reg,     size_next;
    logic [CNT_W-1:0]      left_reg,     left_next;
    logic [7:0]            sum_reg,      sum_next;
    logic [3:0]            ck_hi_reg,    ck_hi_next;
    logic                  res_valid_reg, res_valid_next;
    out_item_t             res_item_reg,  res_item_next;

    logic                  rx_fire;
    logic [7:0]            c;
    logic                  last;
    logic                  is_comma;
    logic                  is_digit;
    logic [4:0]            hex;
    logic                  name_full;
    logic [VAL_W-1:0]      num_acc;
    logic [VAL_W-1:0]      num_acc_next;
    logic                  num_bad;
    logic                  res_emit;
    out_item_t             res_new;
    logic [7:0]            ck_value;

    assign rx_ready = !res_valid_reg || res_ready;
    assign rx_fire  = rx_valid && rx_ready;
    assign c        = rx_item.byte_in;
    assign last     = rx_item.line_end;
    assign is_comma = (c == CHAR_COMMA);
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign hex      = hex_decode(c);
    assign name_full = (name_len_reg >= NAME_W'(NAME_MAX - 1));
    assign ck_value = {ck_hi_reg, hex[3:0]};

    // The decimal field currently being read
    always_comb
    begin
        case (phase_reg)
            PH_COUNT: num_acc = count_reg;
            PH_BLOCK: num_acc = block_reg;
            default:  num_acc = size_reg;
        endcase
    end

    assign num_acc_next = (num_acc << 3) + (num_acc << 1) + VAL_W'(c - 8'h30);
    assign num_bad = is_comma ? (digits_reg == '0)
                              : (!is_digit || digits_reg >= DIGIT_W'(MAX_DIGITS));

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        prefix_next   = prefix_reg;
        name_len_next = name_len_reg;
        digits_next   = digits_reg;
        count_next    = count_reg;
        block_next    = block_reg;
        size_next     = size_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        ck_hi_next    = ck_hi_reg;
        if (rx_fire)
        begin
            if (phase_reg == PH_COUNT || phase_reg == PH_BLOCK || phase_reg == PH_SIZE)
            begin
                if (num_bad)
                    phase_next = PH_DISCARD;
                else if (is_comma)
                    digits_next = '0;
                else
                    digits_next = digits_reg + 1'b1;
            end
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (prefix_reg < PREFIX_W'(PREFIX_LEN) && c == prefix_char(prefix_reg))
                    begin
                        prefix_next = prefix_reg + 1'b1;
                        if (prefix_reg == PREFIX_W'(PREFIX_LEN - 1))
                            phase_next = PH_NAME;
                    end
                    else
                        phase_next = PH_DISCARD;
                end
                PH_NAME:
                begin
                    if (is_comma)
                        phase_next = PH_COUNT;
                    else if (name_full)
                        phase_next = PH_DISCARD;
                    else
                        name_len_next = name_len_reg + 1'b1;
                end
                PH_COUNT:
                begin
                    if (!num_bad)
                    begin
                        if (!is_comma)
                            count_next = num_acc_next;
                        else if (count_reg > VAL_W'(BLOCK_MAX))
                            phase_next = PH_DISCARD;
                        else
                            phase_next = PH_BLOCK;
                    end
                end
                PH_BLOCK:
                begin
                    if (!num_bad)
                    begin
                        if (!is_comma)
                            block_next = num_acc_next;
                        else
                            phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    if (!num_bad)
                    begin
                        if (!is_comma)
                            size_next = num_acc_next;
                        else
                        begin
                            left_next  = count_reg[CNT_W-1:0];
                            phase_next = (count_reg == '0) ? PH_CKHI : PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    sum_next  = sum_reg + c;
                    left_next = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                        phase_next = PH_CKHI;
                end
                PH_CKHI:
                begin
                    if (hex[4])
                    begin
                        ck_hi_next = hex[3:0];
                        phase_next = PH_CKLO;
                    end
                    else
                        phase_next = PH_DISCARD;
                end
                PH_CKLO:    phase_next = PH_DISCARD;
                PH_DISCARD: phase_next = PH_DISCARD;
                default:    phase_next = PH_DISCARD;
            endcase
            // Every line end restarts the parser
            if (last)
            begin
                phase_next    = PH_PREFIX;
                prefix_next   = '0;
                name_len_next = '0;
                digits_next   = '0;
                count_next    = '0;
                block_next    = '0;
                size_next     = '0;
                left_next     = '0;
                sum_next      = '0;
                ck_hi_next    = '0;
            end
        end
    end

    // Result for the byte on the input
    always_comb
    begin
        res_emit = 1'b0;
        res_new  = '0;
        if (last)
        begin
            res_emit = 1'b1;
            if (phase_reg == PH_CKLO && hex[4])
            begin
                res_new.kind              = KIND_VERDICT;
                res_new.block_number      = block_reg;
                res_new.file_size         = size_reg;
                res_new.byte_count        = count_reg[CNT_W-1:0];
                res_new.checksum_ok       = (sum_reg == ck_value);
                res_new.file_missing      = (name_len_reg == '0) && (count_reg == '0)
                                            && (size_reg == '0);
                res_new.checksum_received = ck_value;
            end
            else
                res_new.kind = KIND_REJECT;
        end
        else if (phase_reg == PH_NAME && !is_comma && !name_full)
        begin
            res_emit         = 1'b1;
            res_new.kind     = KIND_NAME;
            res_new.out_byte = c;
        end
        else if (phase_reg == PH_DATA)
        begin
            res_emit         = 1'b1;
            res_new.kind     = KIND_DATA;
            res_new.out_byte = (c == CHAR_BELL) ? CHAR_CR : c;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        if (rx_fire)
        begin
            res_valid_next = res_emit;
            if (res_emit)
                res_item_next = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            prefix_reg    <= '0;
            name_len_reg  <= '0;
            digits_reg    <= '0;
            count_reg     <= '0;
            block_reg     <= '0;
            size_reg      <= '0;
            left_reg      <= '0;
            sum_reg       <= '0;
            ck_hi_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prefix_reg    <= prefix_next;
            name_len_reg  <= name_len_next;
            digits_reg    <= digits_next;
            count_reg     <= count_next;
            block_reg     <= block_next;
            size_reg      <= size_next;
            left_reg      <= left_next;
            sum_reg       <= sum_next;
            ck_hi_reg     <= ck_hi_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

/* hdl/fbfp_checker.sv */
// Port-level checker for the frame parser, bound to the top level.
module fbfp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rx_valid,
    input logic                rx_ready,
    input fbfp_pkg::in_item_t  rx_item,
    input logic                res_valid,
    input logic                res_ready,
    input fbfp_pkg::out_item_t res_item
);
    import fbfp_pkg::*;

    // A waiting result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed or dropped while stalled");

    // Input is never blocked while the output register is empty
    a_rx_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("input stalled with empty output");

    // Line end always yields a verdict or a rejection
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && rx_item.line_end |=>
        res_valid && (res_item.kind == KIND_VERDICT || res_item.kind == KIND_REJECT))
        else $error("line end without verdict");

    // Mid-line bytes never produce a verdict or rejection
    a_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && !rx_item.line_end |=>
        !(res_valid && (res_item.kind == KIND_VERDICT || res_item.kind == KIND_REJECT)))
        else $error("verdict before line end");

    // Header fields are only carried by verdicts
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind != KIND_VERDICT |->
        res_item.block_number == '0 && res_item.file_size == '0
        && res_item.byte_count == '0)
        else $error("header fields set outside a verdict");

endmodule

bind file_block_frame_parser_top fbfp_checker u_fbfp_checker (.*);
